// ===== rtl/core/tacho_pkg.sv =====
// tacho_pkg: shared types and fixed constants of the dual channel tachometer
// no dependencies; imported by the interfaces and every rtl module but tacho_fifo
`timescale 1ns / 1ps
`default_nettype none

package tacho_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned RPM_W  = 26;

    localparam logic [DATA_W-1:0] UPDATE_INTERVAL_RST = 32'd1000;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              engine_level;
        logic              shaft_level;
        logic [DATA_W-1:0] sample_time_us;
        logic [DATA_W-1:0] update_time;
    } t_in_item;

    typedef struct packed {
        logic [RPM_W-1:0] engine_rpm;
        logic [RPM_W-1:0] shaft_rpm;
        logic             recalculated;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/tacho_in_if.sv =====
// tacho_in_if: valid/ready channel carrying one sample or update item
// depends on tacho_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tacho_in_if;
    import tacho_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic              engine_level;
    logic              shaft_level;
    logic [DATA_W-1:0] sample_time_us;
    logic [DATA_W-1:0] update_time;

    modport source (
        output valid, kind, engine_level, shaft_level, sample_time_us, update_time,
        input  ready
    );

    modport sink (
        input  valid, kind, engine_level, shaft_level, sample_time_us, update_time,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/tacho_out_if.sv =====
// tacho_out_if: valid/ready channel carrying one rpm result item
// depends on tacho_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tacho_out_if;
    import tacho_pkg::*;

    logic             valid;
    logic             ready;
    logic [RPM_W-1:0] engine_rpm;
    logic [RPM_W-1:0] shaft_rpm;
    logic             recalculated;

    modport source (
        output valid, engine_rpm, shaft_rpm, recalculated,
        input  ready
    );

    modport sink (
        input  valid, engine_rpm, shaft_rpm, recalculated,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/tacho_fifo.sv =====
// tacho_fifo: small register queue between front and back
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module tacho_fifo #(
    parameter int unsigned WIDTH = 97,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output logic [WIDTH-1:0]      o_pop_data
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             push, pop;

    assign o_push_ready = (r_fill != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/tacho_front.sv =====
// tacho_front: edge detection, interval accumulation and deadline check per item
// depends on tacho_pkg; feeds tacho_fifo
`timescale 1ns / 1ps
`default_nettype none

module tacho_front #(
    parameter int unsigned COUNT_BITS = 16,
    localparam int unsigned ENTRY_W = 1 + 2 * (tacho_pkg::DATA_W + COUNT_BITS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tacho_pkg::DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire tacho_pkg::t_in_item           i_item,
    output logic                               o_push_valid,
    input  wire logic                          i_push_ready,
    output logic [ENTRY_W-1:0]                 o_push_data
);
    import tacho_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [DATA_W-1:0]     r_interval;
    logic [DATA_W-1:0]     r_deadline, n_deadline;
    logic                  r_eng_high, n_eng_high;
    logic [DATA_W-1:0]     r_eng_last, n_eng_last;
    logic [COUNT_BITS-1:0] r_eng_cnt, n_eng_cnt;
    logic [DATA_W-1:0]     r_eng_sum, n_eng_sum;
    logic                  r_sh_high, n_sh_high;
    logic [DATA_W-1:0]     r_sh_last, n_sh_last;
    logic [COUNT_BITS-1:0] r_sh_cnt, n_sh_cnt;
    logic [DATA_W-1:0]     r_sh_sum, n_sh_sum;
    logic                  accept, fire, eng_rise, sh_rise;

    assign accept       = i_valid & i_push_ready;
    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign fire         = (i_item.kind == KIND_UPDATE) && (i_item.update_time > r_deadline);
    assign eng_rise     = i_item.engine_level & ~r_eng_high;
    assign sh_rise      = i_item.shaft_level & ~r_sh_high;
    assign o_push_data  = {fire, r_eng_sum, r_eng_cnt, r_sh_sum, r_sh_cnt};

    always_comb begin
        n_deadline = r_deadline;
        n_eng_high = r_eng_high;
        n_eng_last = r_eng_last;
        n_eng_cnt  = r_eng_cnt;
        n_eng_sum  = r_eng_sum;
        n_sh_high  = r_sh_high;
        n_sh_last  = r_sh_last;
        n_sh_cnt   = r_sh_cnt;
        n_sh_sum   = r_sh_sum;
        if (accept) begin
            if (i_item.kind == KIND_SAMPLE) begin
                n_eng_high = i_item.engine_level;
                n_sh_high  = i_item.shaft_level;
                if (eng_rise) begin
                    n_eng_cnt  = (r_eng_cnt == CNT_MAX) ? r_eng_cnt : r_eng_cnt + 1'b1;
                    n_eng_sum  = r_eng_sum + (i_item.sample_time_us - r_eng_last);
                    n_eng_last = i_item.sample_time_us;
                end
                if (sh_rise) begin
                    n_sh_cnt  = (r_sh_cnt == CNT_MAX) ? r_sh_cnt : r_sh_cnt + 1'b1;
                    n_sh_sum  = r_sh_sum + (i_item.sample_time_us - r_sh_last);
                    n_sh_last = i_item.sample_time_us;
                end
            end else if (fire) begin
                n_eng_cnt  = '0;
                n_eng_sum  = '0;
                n_sh_cnt   = '0;
                n_sh_sum   = '0;
                n_deadline = i_item.update_time + r_interval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= UPDATE_INTERVAL_RST;
            r_deadline <= '0;
            r_eng_high <= 1'b0;
            r_eng_last <= '0;
            r_eng_cnt  <= '0;
            r_eng_sum  <= '0;
            r_sh_high  <= 1'b0;
            r_sh_last  <= '0;
            r_sh_cnt   <= '0;
            r_sh_sum   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            r_deadline <= n_deadline;
            r_eng_high <= n_eng_high;
            r_eng_last <= n_eng_last;
            r_eng_cnt  <= n_eng_cnt;
            r_eng_sum  <= n_eng_sum;
            r_sh_high  <= n_sh_high;
            r_sh_last  <= n_sh_last;
            r_sh_cnt   <= n_sh_cnt;
            r_sh_sum   <= n_sh_sum;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/tacho_div.sv =====
// tacho_div: restoring unsigned divider, one quotient bit per cycle
// depends on tacho_pkg
`timescale 1ns / 1ps
`default_nettype none

module tacho_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tacho_pkg::DATA_W-1:0]  i_dividend,
    input  wire logic [tacho_pkg::DATA_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [tacho_pkg::DATA_W-1:0]       o_quotient
);
    import tacho_pkg::*;

    localparam int unsigned STEP_W = $clog2(DATA_W);

    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    assign trial      = {r_rem, r_quo[DATA_W-1]};
    assign diff       = trial - {1'b0, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= STEP_W'(DATA_W - 1);
        end else if (r_busy) begin
            r_rem  <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
            r_quo  <= {r_quo[DATA_W-2:0], ~diff[DATA_W]};
            r_step <= r_step - 1'b1;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/tacho_back.sv =====
// tacho_back: in-order executor, rpm recalculation sequencer and output register
// depends on tacho_pkg and tacho_div
`timescale 1ns / 1ps
`default_nettype none

module tacho_back #(
    parameter int unsigned MICROS_PER_MINUTE = 60000000,
    parameter int unsigned COUNT_BITS = 16,
    localparam int unsigned ENTRY_W = 1 + 2 * (tacho_pkg::DATA_W + COUNT_BITS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_pop_valid,
    output logic                       o_pop_ready,
    input  wire logic [ENTRY_W-1:0]    i_pop_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output tacho_pkg::t_out_item       o_out_item
);
    import tacho_pkg::*;

    localparam logic [DATA_W-1:0] MPM = DATA_W'(MICROS_PER_MINUTE);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_ENG_GO  = 8'b0000_0010,
        ST_ENG_AVG = 8'b0000_0100,
        ST_ENG_RPM = 8'b0000_1000,
        ST_SH_GO   = 8'b0001_0000,
        ST_SH_AVG  = 8'b0010_0000,
        ST_SH_RPM  = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } t_back_state;

    t_back_state           r_state, n_state;
    logic [RPM_W-1:0]      r_eng_speed, n_eng_speed;
    logic [RPM_W-1:0]      r_sh_speed, n_sh_speed;
    logic [DATA_W-1:0]     r_eng_sum;
    logic [COUNT_BITS-1:0] r_eng_cnt;
    logic [DATA_W-1:0]     r_sh_sum;
    logic [COUNT_BITS-1:0] r_sh_cnt;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  pop_fired;
    logic [DATA_W-1:0]     pop_eng_sum, pop_sh_sum;
    logic [COUNT_BITS-1:0] pop_eng_cnt, pop_sh_cnt;
    logic                  slot_free, latch, load_out, recalc;
    logic                  div_start, div_done;
    logic [DATA_W-1:0]     div_dividend, div_divisor, div_q;

    assign {pop_fired, pop_eng_sum, pop_eng_cnt, pop_sh_sum, pop_sh_cnt} = i_pop_data;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_pop_ready = (r_state == ST_IDLE) && slot_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    tacho_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state      = r_state;
        n_eng_speed  = r_eng_speed;
        n_sh_speed   = r_sh_speed;
        latch        = 1'b0;
        load_out     = 1'b0;
        recalc       = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_pop_valid && slot_free) begin
                    if (pop_fired) begin
                        latch   = 1'b1;
                        n_state = ST_ENG_GO;
                    end else begin
                        load_out = 1'b1;
                    end
                end
            end
            ST_ENG_GO: begin
                if (r_eng_cnt != '0) begin
                    div_start    = 1'b1;
                    div_dividend = r_eng_sum;
                    div_divisor  = DATA_W'(r_eng_cnt);
                    n_state      = ST_ENG_AVG;
                end else begin
                    n_state = ST_SH_GO;
                end
            end
            ST_ENG_AVG: begin
                if (div_done) begin
                    if (div_q != '0) begin
                        div_start    = 1'b1;
                        div_dividend = MPM;
                        div_divisor  = div_q;
                        n_state      = ST_ENG_RPM;
                    end else begin
                        n_state = ST_SH_GO;
                    end
                end
            end
            ST_ENG_RPM: begin
                if (div_done) begin
                    n_eng_speed = div_q[RPM_W-1:0];
                    n_state     = ST_SH_GO;
                end
            end
            ST_SH_GO: begin
                if (r_sh_cnt != '0) begin
                    div_start    = 1'b1;
                    div_dividend = r_sh_sum;
                    div_divisor  = DATA_W'(r_sh_cnt);
                    n_state      = ST_SH_AVG;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SH_AVG: begin
                if (div_done) begin
                    if (div_q != '0) begin
                        div_start    = 1'b1;
                        div_dividend = MPM;
                        div_divisor  = div_q;
                        n_state      = ST_SH_RPM;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SH_RPM: begin
                if (div_done) begin
                    n_sh_speed = div_q[RPM_W-1:0];
                    n_state    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    recalc   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load_out) begin
            n_out_valid        = 1'b1;
            n_out.engine_rpm   = r_eng_speed;
            n_out.shaft_rpm    = r_sh_speed;
            n_out.recalculated = recalc;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_eng_speed <= '0;
            r_sh_speed  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_eng_speed <= n_eng_speed;
            r_sh_speed  <= n_sh_speed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (latch) begin
            r_eng_sum <= pop_eng_sum;
            r_eng_cnt <= pop_eng_cnt;
            r_sh_sum  <= pop_sh_sum;
            r_sh_cnt  <= pop_sh_cnt;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/dual_channel_tachometer.sv =====
// channel   dir  handshake            payload
// i_in      in   valid/ready          kind, engine_level, shaft_level, sample_time_us, update_time
// o_out     out  valid/ready          engine_rpm, shaft_rpm, recalculated
// cfg       in   i_cfg_we, no ready   i_cfg_wdata = update_interval
//
// pin samples and update checks that do not fire pass at one item per cycle while o_out
// takes every result; an update check that fires runs up to four divisions in turn on
// one shared divider, while the two-entry queue fills and i_in stalls
// results leave in item order through a registered output stage
// i_rst_n is synchronous; the front's counters and sums, the speeds and the deadline clear
// top level: front, queue and back of the tachometer; depends on tacho_pkg and both interfaces
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_tachometer #(
    parameter int unsigned MICROS_PER_MINUTE = 60000000,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tacho_pkg::DATA_W-1:0]  i_cfg_wdata,
    tacho_in_if.sink                           i_in,
    tacho_out_if.source                        o_out
);
    import tacho_pkg::*;

    localparam int unsigned ENTRY_W = 1 + 2 * (DATA_W + COUNT_BITS);

    t_in_item         in_item;
    t_out_item        out_item;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;
    logic [ENTRY_W-1:0] push_data, pop_data;
    logic             front_ready;
    logic             out_valid;

    assign in_item.kind           = i_in.kind;
    assign in_item.engine_level   = i_in.engine_level;
    assign in_item.shaft_level    = i_in.shaft_level;
    assign in_item.sample_time_us = i_in.sample_time_us;
    assign in_item.update_time    = i_in.update_time;
    assign i_in.ready             = front_ready;

    assign o_out.valid        = out_valid;
    assign o_out.engine_rpm   = out_item.engine_rpm;
    assign o_out.shaft_rpm    = out_item.shaft_rpm;
    assign o_out.recalculated = out_item.recalculated;

    tacho_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_in.valid),
        .o_ready      (front_ready),
        .i_item       (in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    tacho_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    tacho_back #(
        .MICROS_PER_MINUTE (MICROS_PER_MINUTE),
        .COUNT_BITS        (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );
endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: self-checking bench for dual_channel_tachometer, random and directed items
// depends on tacho_pkg, tacho_in_if, tacho_out_if and the rtl top level
// predicts every rpm result in step with the input handshake and compares field by field
`timescale 1ns / 1ps

module testbench;
    import tacho_pkg::*;

    localparam int unsigned MICROS_PER_MINUTE = 60000000;
    localparam int unsigned COUNT_BITS        = 16;
    localparam int unsigned CYCLE_LIMIT       = 3000000;
    localparam int unsigned FLOOD_SAMPLES     = 120;
    localparam int unsigned PHASE_ITEMS       = 240;

    typedef struct {
        bit                  high;
        bit [DATA_W-1:0]     last_edge;
        bit [COUNT_BITS-1:0] edges;
        bit [DATA_W-1:0]     span_sum;
        bit [RPM_W-1:0]      rpm;
    } t_pulse_chan;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    tacho_in_if  in_ch ();
    tacho_out_if out_ch ();

    dual_channel_tachometer #(
        .MICROS_PER_MINUTE (MICROS_PER_MINUTE),
        .COUNT_BITS        (COUNT_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // rpm tracker state
    t_pulse_chan     eng_trk;
    t_pulse_chan     shf_trk;
    bit [DATA_W-1:0] period_deadline;
    bit [DATA_W-1:0] period_len = UPDATE_INTERVAL_RST;

    t_in_item  tach_items[$];
    t_out_item rpm_expected[$];
    t_in_item  drv_item;
    t_out_item rpm_want;

    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned items_taken;
    int unsigned results_seen;
    int unsigned recalc_seen;
    int          burst_left = 1;
    int          gap_left;
    bit [31:0]   ready_pattern = '1;
    bit [4:0]    pattern_pos;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void track_pin(inout t_pulse_chan c, input logic level,
                                      input logic [DATA_W-1:0] now);
        if (level) begin
            if (!c.high) begin
                c.high = 1'b1;
                if (c.edges != '1)
                    c.edges++;
                c.span_sum  = c.span_sum + (now - c.last_edge);
                c.last_edge = now;
            end
        end else begin
            c.high = 1'b0;
        end
    endfunction

    function automatic void close_period(inout t_pulse_chan c);
        bit [DATA_W-1:0] avg;
        if (c.edges != 0) begin
            avg = c.span_sum / c.edges;
            if (avg != 0)
                c.rpm = RPM_W'(MICROS_PER_MINUTE / avg);
        end
        c.edges    = '0;
        c.span_sum = '0;
    endfunction

    function automatic t_out_item predict_rpm(t_in_item it);
        t_out_item res;
        res.recalculated = 1'b0;
        if (it.kind == KIND_SAMPLE) begin
            track_pin(eng_trk, it.engine_level, it.sample_time_us);
            track_pin(shf_trk, it.shaft_level, it.sample_time_us);
        end else if (it.update_time > period_deadline) begin
            close_period(eng_trk);
            close_period(shf_trk);
            period_deadline  = it.update_time + period_len;
            res.recalculated = 1'b1;
        end
        res.engine_rpm = eng_trk.rpm;
        res.shaft_rpm  = shf_trk.rpm;
        return res;
    endfunction

    function automatic t_in_item pin_item(bit e, bit s, bit [DATA_W-1:0] t);
        t_in_item it;
        it.kind           = KIND_SAMPLE;
        it.engine_level   = e;
        it.shaft_level    = s;
        it.sample_time_us = t;
        it.update_time    = $urandom;
        return it;
    endfunction

    function automatic t_in_item clock_item(bit [DATA_W-1:0] ut);
        t_in_item it;
        it.kind           = KIND_UPDATE;
        it.engine_level   = 1'($urandom_range(0, 1));
        it.shaft_level    = 1'($urandom_range(0, 1));
        it.sample_time_us = $urandom;
        it.update_time    = ut;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 40)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        fail_count++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (tach_items.size() != 0 || in_ch.valid || rpm_expected.size() != 0);
    endtask

    task automatic write_interval(input bit [DATA_W-1:0] v);
        wait_idle();
        @(posedge i_clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        period_len  = v;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                rpm_expected.push_back(predict_rpm(drv_item));
                items_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0 || tach_items.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    in_ch.valid <= 1'b0;
                end else begin
                    drv_item              = tach_items.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.kind           <= drv_item.kind;
                    in_ch.engine_level   <= drv_item.engine_level;
                    in_ch.shaft_level    <= drv_item.shaft_level;
                    in_ch.sample_time_us <= drv_item.sample_time_us;
                    in_ch.update_time    <= drv_item.update_time;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: stall pattern redrawn whenever the pattern position wraps, sometimes never stalling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (rpm_expected.size() == 0) begin
                    report_mismatch("unexpected result", 32'(out_ch.engine_rpm), '0);
                end else begin
                    rpm_want = rpm_expected.pop_front();
                    if (rpm_want.recalculated)
                        recalc_seen++;
                    if (out_ch.engine_rpm !== rpm_want.engine_rpm)
                        report_mismatch("engine_rpm", 32'(out_ch.engine_rpm),
                                        32'(rpm_want.engine_rpm));
                    if (out_ch.shaft_rpm !== rpm_want.shaft_rpm)
                        report_mismatch("shaft_rpm", 32'(out_ch.shaft_rpm),
                                        32'(rpm_want.shaft_rpm));
                    if (out_ch.recalculated !== rpm_want.recalculated)
                        report_mismatch("recalculated", 32'(out_ch.recalculated),
                                        32'(rpm_want.recalculated));
                end
            end
            out_ch.ready <= ready_pattern[pattern_pos];
            pattern_pos++;
            if (pattern_pos == 0)
                ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_in_item        it;
        bit [DATA_W-1:0] wave_now;
        bit [DATA_W-1:0] upd_clock;
        bit [DATA_W-1:0] interval;
        int              sel;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset interval: first interval from zero, zero average, equal deadline
        tach_items.push_back(pin_item(1, 0, 0));
        tach_items.push_back(clock_item(0));
        tach_items.push_back(clock_item(1));
        tach_items.push_back(pin_item(0, 0, 10));
        tach_items.push_back(pin_item(1, 1, 1000));
        tach_items.push_back(pin_item(1, 1, 2000));
        tach_items.push_back(pin_item(0, 0, 3000));
        tach_items.push_back(pin_item(1, 1, 4000));
        tach_items.push_back(clock_item(1001));
        tach_items.push_back(clock_item(1002));
        tach_items.push_back(pin_item(1, 0, 4000));
        // one microsecond period gives the top rpm, idle engine keeps its value
        tach_items.push_back(pin_item(0, 1, 4001));
        tach_items.push_back(clock_item(2003));
        // timestamp wrap and deadline wrap
        tach_items.push_back(pin_item(1, 0, 32'hFFFF_FFF0));
        tach_items.push_back(pin_item(0, 0, 32'hFFFF_FFF8));
        tach_items.push_back(pin_item(1, 1, 32'h0000_0010));
        tach_items.push_back(clock_item('1));
        it = pin_item(0, 0, '1);
        it.update_time = '1;
        tach_items.push_back(it);
        it = clock_item(999);
        it.engine_level   = 1'b1;
        it.shaft_level    = 1'b1;
        it.sample_time_us = '1;
        tach_items.push_back(it);
        tach_items.push_back(clock_item(1000));
        it = pin_item(1, 1, 0);
        it.update_time = '0;
        tach_items.push_back(it);

        // dense edge train on both channels with a zero update interval
        write_interval('0);
        tach_items.push_back(clock_item(3000));
        wave_now = 100;
        for (int k = 0; k < FLOOD_SAMPLES; k++) begin
            wave_now += 3;
            tach_items.push_back(pin_item(k[0], k[0], wave_now));
        end
        tach_items.push_back(clock_item(5000));
        tach_items.push_back(clock_item(5001));

        upd_clock = 6000;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: interval = '0;
                1: interval = '1;
                2: interval = UPDATE_INTERVAL_RST;
                3: interval = $urandom_range(1, 5000);
                default: interval = $urandom;
            endcase
            write_interval(interval);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 47);
                if (sel < 6) begin
                    // noise: every field at random
                    it.kind           = 1'($urandom_range(0, 1));
                    it.engine_level   = 1'($urandom_range(0, 1));
                    it.shaft_level    = 1'($urandom_range(0, 1));
                    it.sample_time_us = $urandom;
                    it.update_time    = $urandom;
                end else if (sel < 14) begin
                    if (interval == 0)
                        upd_clock += $urandom_range(0, 3);
                    else
                        upd_clock += (interval >> 2) * $urandom_range(0, 6) + $urandom_range(0, 2);
                    it = clock_item(upd_clock);
                end else begin
                    sel = $urandom_range(0, 15);
                    if (sel == 0)
                        wave_now += $urandom;
                    else if (sel < 3)
                        wave_now += $urandom_range(0, 1 << 20);
                    else
                        wave_now += $urandom_range(0, 200);
                    it = pin_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), wave_now);
                end
                tach_items.push_back(it);
            end
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("run covered %0d items and %0d results, %0d of them rpm recalculations",
                 items_taken, results_seen, recalc_seen);
        $display("update intervals swept from zero to all ones, timestamps and deadlines wrapped");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== dual_channel_tachometer.f =====
rtl/core/tacho_pkg.sv
rtl/core/tacho_in_if.sv
rtl/core/tacho_out_if.sv
rtl/core/tacho_fifo.sv
rtl/core/tacho_front.sv
rtl/core/tacho_div.sv
rtl/core/tacho_back.sv
rtl/core/dual_channel_tachometer.sv
dv/testbench.sv
